/* sv/tdg_pkg.sv */
// ----------------------------------------------------------------------------
// tdg_pkg: shared types and constants for the touch drag gesture filter
// Holds the event and result records, the event and register codes, and the
// configuration reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package tdg_pkg;

  localparam int unsigned POS_W  = 10;
  localparam int unsigned ID_W   = 8;
  localparam int unsigned PAN_W  = 12;
  localparam int unsigned CFGI_W = 3;
  localparam int unsigned CFGD_W = 10;

  // Event kinds; the unused code is handled as a move
  typedef enum logic [1:0] {
    OP_DOWN = 2'd0,
    OP_UP   = 2'd1,
    OP_MOVE = 2'd2
  } op_t;

  // Configuration register indexes
  typedef enum logic [CFGI_W-1:0] {
    REG_SLOP_RADIUS  = 3'd0,
    REG_MAX_PAN_STEP = 3'd1,
    REG_BUTTON_MIN_X = 3'd2,
    REG_BUTTON_MIN_Y = 3'd3,
    REG_BUTTON_MAX_Y = 3'd4
  } cfg_reg_t;

  localparam logic [7:0]       SLOP_RADIUS_RST  = 8'd16;
  localparam logic [7:0]       MAX_PAN_STEP_RST = 8'd36;
  localparam logic [POS_W-1:0] BUTTON_MIN_X_RST = 10'd880;
  localparam logic [POS_W-1:0] BUTTON_MIN_Y_RST = 10'd380;
  localparam logic [POS_W-1:0] BUTTON_MAX_Y_RST = 10'd470;

  typedef struct packed {
    logic [7:0]       slop_radius;
    logic [7:0]       max_pan_step;
    logic [POS_W-1:0] button_min_x;
    logic [POS_W-1:0] button_min_y;
    logic [POS_W-1:0] button_max_y;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       op;
    logic [ID_W-1:0]  touch_id;
    logic [POS_W-1:0] pos_x;
    logic [POS_W-1:0] pos_y;
    logic             selection_enabled;
  } evt_t;

  typedef struct packed {
    logic [1:0]              action;
    logic [ID_W-1:0]         out_id;
    logic [POS_W-1:0]        out_x;
    logic [POS_W-1:0]        out_y;
    logic                    pan_valid;
    logic signed [PAN_W-1:0] pan_dx;
    logic signed [PAN_W-1:0] pan_dy;
    logic                    armed_now;
  } res_t;

  // Motion state the arithmetic needs
  typedef struct packed {
    logic             moved;
    logic             selection_drag;
    logic [POS_W-1:0] down_x;
    logic [POS_W-1:0] down_y;
    logic [POS_W-1:0] last_x;
    logic [POS_W-1:0] last_y;
  } mot_state_t;

  // Motion arithmetic results
  typedef struct packed {
    logic                    inside_slop;
    logic                    nonzero;
    logic signed [PAN_W-1:0] pan_dx;
    logic signed [PAN_W-1:0] pan_dy;
  } mot_res_t;

endpackage

`default_nettype wire

/* sv/touch_drag_gesture_filter_core.sv */
// Two register stages, the input register and then the result register, lie
// between an accepted request and its presented result.
// Throughput: one event per cycle while the result register is not stalled.
// A stalled result register holds a full input register, which then drops ready.
// Reset (rst_n low, synchronous) empties both stages, clears the touch state
// and loads the configuration registers with their default values.
// ----------------------------------------------------------------------------
// touch_drag_gesture_filter_core: touch slop and drag detector
// Registers each touch event, runs it through the tracker and forwards it
// with an optional pan delta and a selection arm flag.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_drag_gesture_filter_core import tdg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // Input events
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [31:0]       in_tdata,  // touch_id[7:0], pos_x[17:8], pos_y[27:18],
                                            // selection_enabled[28], zero[31:29]
  input  wire logic [1:0]        in_tuser,  // op[1:0]
  // Results
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [55:0]            out_tdata, // out_id[7:0], out_x[17:8], out_y[27:18],
                                            // pan_valid[28], pan_dx[40:29],
                                            // pan_dy[52:41], armed_now[53], zero[55:54]
  output logic [1:0]             out_tuser, // action[1:0]
  // Configuration writes
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFGI_W-1:0] cfg_index,
  input  wire logic [CFGD_W-1:0] cfg_data
);

  cfg_t cfg_r;
  evt_t evt_r;
  logic in_v_r;
  res_t res;
  res_t out_r;
  logic out_v_r;
  logic advance;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slop_radius  <= SLOP_RADIUS_RST;
      cfg_r.max_pan_step <= MAX_PAN_STEP_RST;
      cfg_r.button_min_x <= BUTTON_MIN_X_RST;
      cfg_r.button_min_y <= BUTTON_MIN_Y_RST;
      cfg_r.button_max_y <= BUTTON_MAX_Y_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SLOP_RADIUS:  cfg_r.slop_radius  <= cfg_data[7:0];
        REG_MAX_PAN_STEP: cfg_r.max_pan_step <= cfg_data[7:0];
        REG_BUTTON_MIN_X: cfg_r.button_min_x <= cfg_data;
        REG_BUTTON_MIN_Y: cfg_r.button_min_y <= cfg_data;
        REG_BUTTON_MAX_Y: cfg_r.button_max_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // Pipeline flow: the input stage moves when the result register is free
  assign advance   = !out_v_r || out_tready;
  assign in_tready = !in_v_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      evt_r.op                <= in_tuser;
      evt_r.touch_id          <= in_tdata[7:0];
      evt_r.pos_x             <= in_tdata[17:8];
      evt_r.pos_y             <= in_tdata[27:18];
      evt_r.selection_enabled <= in_tdata[28];
    end
  end

  tdg_tracker u_tracker (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (in_v_r && advance),
    .evt   (evt_r),
    .cfg   (cfg_r),
    .res   (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (advance) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_v_r) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.action;
  assign out_tdata  = {2'b00, out_r.armed_now, out_r.pan_dy, out_r.pan_dx,
                       out_r.pan_valid, out_r.out_y, out_r.out_x, out_r.out_id};

  ap_pan_only_on_move: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.pan_valid) |-> (out_r.action == OP_MOVE))
    else $error("pan delta on a non-move result");

  ap_arm_only_on_up: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.armed_now) |-> (out_r.action == OP_UP))
    else $error("selection armed by a non-release result");

  ap_no_pan_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_r.pan_valid) |-> (out_r.pan_dx == '0 && out_r.pan_dy == '0))
    else $error("pan delta nonzero without pan_valid");

  ap_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && out_v_r && !out_tready) |-> !in_tready)
    else $error("input taken while both stages are held");

endmodule

`default_nettype wire

/* sv/tdg_motion.sv */
// ----------------------------------------------------------------------------
// tdg_motion: slop test and pan delta arithmetic
// Forms the delta from the down or last point, checks it against the slop
// circle and scales or clamps it into a half-pixel pan delta.
// ----------------------------------------------------------------------------
`default_nettype none

module tdg_motion import tdg_pkg::*; (
  input  wire logic [POS_W-1:0] pos_x,
  input  wire logic [POS_W-1:0] pos_y,
  input  wire mot_state_t       st,
  input  wire logic [7:0]       slop_radius,
  input  wire logic [7:0]       max_pan_step,
  output mot_res_t              res
);

  logic             use_last;
  logic [POS_W-1:0] ref_x;
  logic [POS_W-1:0] ref_y;
  logic signed [POS_W:0]     dx;
  logic signed [POS_W:0]     dy;
  logic signed [2*POS_W+1:0] sq_x;
  logic signed [2*POS_W+1:0] sq_y;
  logic [2*POS_W+1:0]        dist2;
  logic [15:0]               slop2;
  logic signed [POS_W+2:0]   dx_ext;
  logic signed [POS_W+2:0]   dy_ext;
  logic signed [POS_W+2:0]   tri_x;
  logic signed [POS_W+2:0]   tri_y;
  logic signed [POS_W+2:0]   lim;
  logic signed [POS_W+2:0]   clamp_x;
  logic signed [POS_W+2:0]   clamp_y;

  // Pick the reference point: last point only for a normal drag in progress
  assign use_last = st.moved && !st.selection_drag;
  assign ref_x    = use_last ? st.last_x : st.down_x;
  assign ref_y    = use_last ? st.last_y : st.down_y;

  assign dx = $signed({1'b0, pos_x}) - $signed({1'b0, ref_x});
  assign dy = $signed({1'b0, pos_y}) - $signed({1'b0, ref_y});

  // Squared distance against squared slop radius
  assign sq_x  = $signed({{(POS_W+1){dx[POS_W]}}, dx}) *
                 $signed({{(POS_W+1){dx[POS_W]}}, dx});
  assign sq_y  = $signed({{(POS_W+1){dy[POS_W]}}, dy}) *
                 $signed({{(POS_W+1){dy[POS_W]}}, dy});
  assign dist2 = {1'b0, sq_x[2*POS_W:0]} + {1'b0, sq_y[2*POS_W:0]};
  assign slop2 = {8'd0, slop_radius} * {8'd0, slop_radius};

  // Scale by 1.5 pixels (3 half pixels) and clamp to twice the max step
  assign dx_ext = {{2{dx[POS_W]}}, dx};
  assign dy_ext = {{2{dy[POS_W]}}, dy};
  assign tri_x  = dx_ext + (dx_ext <<< 1);
  assign tri_y  = dy_ext + (dy_ext <<< 1);
  assign lim    = $signed({4'b0000, max_pan_step, 1'b0});

  always_comb begin
    priority if (tri_x > lim) begin
      clamp_x = lim;
    end else if (tri_x < -lim) begin
      clamp_x = -lim;
    end else begin
      clamp_x = tri_x;
    end
    priority if (tri_y > lim) begin
      clamp_y = lim;
    end else if (tri_y < -lim) begin
      clamp_y = -lim;
    end else begin
      clamp_y = tri_y;
    end
  end

  always_comb begin
    res.inside_slop = dist2 < {6'd0, slop2};
    res.nonzero     = (dx != '0) || (dy != '0);
    if (st.selection_drag) begin
      res.pan_dx = {dx, 1'b0};
      res.pan_dy = {dy, 1'b0};
    end else begin
      res.pan_dx = clamp_x[PAN_W-1:0];
      res.pan_dy = clamp_y[PAN_W-1:0];
    end
  end

endmodule

`default_nettype wire

/* sv/tdg_tracker.sv */
// ----------------------------------------------------------------------------
// tdg_tracker: active touch state and per-event decision
// Keeps the active touch, its down and last points and the gesture flags,
// and turns one event into one result while updating that state.
// ----------------------------------------------------------------------------
`default_nettype none

module tdg_tracker import tdg_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic step,
  input  wire evt_t evt,
  input  wire cfg_t cfg,
  output res_t      res
);

  logic             moved_r, moved_nxt;
  logic             active_valid_r, active_valid_nxt;
  logic [ID_W-1:0]  active_touch_r, active_touch_nxt;
  logic [POS_W-1:0] down_x_r, down_x_nxt;
  logic [POS_W-1:0] down_y_r, down_y_nxt;
  logic [POS_W-1:0] last_x_r, last_x_nxt;
  logic [POS_W-1:0] last_y_r, last_y_nxt;
  logic             selection_armed_r, selection_armed_nxt;
  logic             selection_drag_r, selection_drag_nxt;

  mot_state_t mst;
  mot_res_t   mres;
  logic       match;
  logic       in_button;
  logic       go;

  assign mst.moved          = moved_r;
  assign mst.selection_drag = selection_drag_r;
  assign mst.down_x         = down_x_r;
  assign mst.down_y         = down_y_r;
  assign mst.last_x         = last_x_r;
  assign mst.last_y         = last_y_r;

  tdg_motion u_motion (
    .pos_x        (evt.pos_x),
    .pos_y        (evt.pos_y),
    .st           (mst),
    .slop_radius  (cfg.slop_radius),
    .max_pan_step (cfg.max_pan_step),
    .res          (mres)
  );

  assign match     = active_valid_r && (active_touch_r == evt.touch_id);
  assign in_button = (evt.pos_x >= cfg.button_min_x) &&
                     (evt.pos_y >= cfg.button_min_y) &&
                     (evt.pos_y <= cfg.button_max_y);

  // Decide the event and the next state
  always_comb begin
    moved_nxt           = moved_r;
    active_valid_nxt    = active_valid_r;
    active_touch_nxt    = active_touch_r;
    down_x_nxt          = down_x_r;
    down_y_nxt          = down_y_r;
    last_x_nxt          = last_x_r;
    last_y_nxt          = last_y_r;
    selection_armed_nxt = selection_armed_r;
    selection_drag_nxt  = selection_drag_r;
    go                  = 1'b0;

    res.action    = evt.op;
    res.out_id    = evt.touch_id;
    res.out_x     = evt.pos_x;
    res.out_y     = evt.pos_y;
    res.pan_valid = 1'b0;
    res.pan_dx    = '0;
    res.pan_dy    = '0;
    res.armed_now = 1'b0;

    unique case (op_t'(evt.op))
      OP_DOWN: begin
        moved_nxt           = 1'b0;
        active_valid_nxt    = 1'b1;
        active_touch_nxt    = evt.touch_id;
        selection_drag_nxt  = selection_armed_r;
        selection_armed_nxt = 1'b0;
        down_x_nxt          = evt.pos_x;
        down_y_nxt          = evt.pos_y;
        last_x_nxt          = evt.pos_x;
        last_y_nxt          = evt.pos_y;
      end
      OP_UP: begin
        if (match) begin
          active_valid_nxt = 1'b0;
        end
        // Arm selection on an untouched release inside the button region
        if (!moved_r && in_button) begin
          selection_armed_nxt = 1'b1;
          res.armed_now       = 1'b1;
        end
      end
      default: begin
        res.action = OP_MOVE;
        if (match) begin
          go = 1'b1;
          if (!moved_r) begin
            if (mres.inside_slop) begin
              go = 1'b0;
            end else if (!evt.selection_enabled) begin
              // First crossing only starts the drag
              moved_nxt  = 1'b1;
              last_x_nxt = evt.pos_x;
              last_y_nxt = evt.pos_y;
              go         = 1'b0;
            end
          end
          if (go && mres.nonzero) begin
            res.pan_valid = 1'b1;
            res.pan_dx    = mres.pan_dx;
            res.pan_dy    = mres.pan_dy;
            last_x_nxt    = evt.pos_x;
            last_y_nxt    = evt.pos_y;
            moved_nxt     = 1'b1;
          end
        end
      end
    endcase
  end

  // Hold control state, commit on each step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moved_r           <= 1'b0;
      active_valid_r    <= 1'b0;
      active_touch_r    <= '0;
      selection_armed_r <= 1'b0;
      selection_drag_r  <= 1'b0;
    end else if (step) begin
      moved_r           <= moved_nxt;
      active_valid_r    <= active_valid_nxt;
      active_touch_r    <= active_touch_nxt;
      selection_armed_r <= selection_armed_nxt;
      selection_drag_r  <= selection_drag_nxt;
    end
  end

  // Positions are only read once a touch went down
  always_ff @(posedge clk) begin
    if (step) begin
      down_x_r <= down_x_nxt;
      down_y_r <= down_y_nxt;
      last_x_r <= last_x_nxt;
      last_y_r <= last_y_nxt;
    end
  end

  ap_down_activates: assert property (@(posedge clk) disable iff (!rst_n)
    (step && evt.op == OP_DOWN) |=> active_valid_r && !moved_r && !selection_armed_r)
    else $error("down event did not open a fresh touch");

endmodule

`default_nettype wire

/* tb/touch_drag_gesture_filter_core_test.sv */
// ----------------------------------------------------------------------------
// touch_drag_gesture_filter_core_test: self-checking bench for the drag filter
// Streams touch events through the core while both sides idle at random and
// checks every forwarded event against a cycle-free tracker model. The
// directed opening covers the slop and clamp edges and the selection gesture.
// Random phases then run gestures under several register settings.
// ----------------------------------------------------------------------------
module touch_drag_gesture_filter_core_test;
  import tdg_pkg::*;

  // Op code with no event kind of its own; the core treats it as a move
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [31:0]       in_tdata = '0;  // touch_id[7:0], pos_x[17:8], pos_y[27:18],
                                     // selection_enabled[28], zero[31:29]
  logic [1:0]        in_tuser = '0;  // op[1:0]
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [55:0]       out_tdata;      // out_id[7:0], out_x[17:8], out_y[27:18],
                                     // pan_valid[28], pan_dx[40:29],
                                     // pan_dy[52:41], armed_now[53], zero[55:54]
  logic [1:0]        out_tuser;      // action[1:0]
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CFGI_W-1:0] cfg_index = '0;
  logic [CFGD_W-1:0] cfg_data = '0;

  touch_drag_gesture_filter_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Tracker copy: settings and touch state
  cfg_t             cfg_model;
  logic             trk_moved;
  logic             trk_active;
  logic [ID_W-1:0]  trk_id;
  logic [POS_W-1:0] trk_down_x, trk_down_y;
  logic [POS_W-1:0] trk_last_x, trk_last_y;
  logic             trk_sel_armed;
  logic             trk_sel_drag;

  evt_t pending_events[$];
  res_t expected_results[$];
  evt_t offered_event;
  res_t predicted;

  int   events_in_flight = 0;
  int   events_queued = 0;
  int   events_accepted = 0;
  int   results_checked = 0;
  int   pans_seen = 0;
  int   arms_seen = 0;
  int   settings_used = 1;
  int   mismatches = 0;
  int   send_gap = 0;
  int   recv_gap = 0;
  bit   idle_gaps = 1'b1;
  logic hold_off = 1'b0;

  // Pick an idle stretch: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_gaps || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic int clamp_pan(int v, int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Advance the tracker by one event and form the forwarded result
  task automatic track_touch(input evt_t ev, output res_t r);
    int  x, y, dx, dy, slop, lim;
    bit  go;
    x = int'(ev.pos_x);
    y = int'(ev.pos_y);
    dx = 0;
    dy = 0;
    r = '0;
    r.out_id = ev.touch_id;
    r.out_x = ev.pos_x;
    r.out_y = ev.pos_y;
    if (ev.op == OP_DOWN) begin
      r.action = OP_DOWN;
      trk_moved = 1'b0;
      trk_active = 1'b1;
      trk_id = ev.touch_id;
      trk_sel_drag = trk_sel_armed;
      trk_sel_armed = 1'b0;
      trk_down_x = ev.pos_x;
      trk_down_y = ev.pos_y;
      trk_last_x = ev.pos_x;
      trk_last_y = ev.pos_y;
    end else if (ev.op == OP_UP) begin
      r.action = OP_UP;
      if (trk_active && trk_id == ev.touch_id) trk_active = 1'b0;
      if (!trk_moved && ev.pos_x >= cfg_model.button_min_x &&
          ev.pos_y >= cfg_model.button_min_y && ev.pos_y <= cfg_model.button_max_y) begin
        trk_sel_armed = 1'b1;
        r.armed_now = 1'b1;
      end
    end else begin
      r.action = OP_MOVE;
      if (trk_active && trk_id == ev.touch_id) begin
        go = 1'b1;
        if (!trk_moved) begin
          slop = int'(cfg_model.slop_radius);
          dx = x - int'(trk_down_x);
          dy = y - int'(trk_down_y);
          if (dx * dx + dy * dy < slop * slop) begin
            go = 1'b0;
          end else if (!ev.selection_enabled) begin
            // first crossing in normal mode only starts the drag
            trk_moved = 1'b1;
            trk_last_x = ev.pos_x;
            trk_last_y = ev.pos_y;
            go = 1'b0;
          end
        end else if (trk_sel_drag) begin
          dx = x - int'(trk_down_x);
          dy = y - int'(trk_down_y);
        end else begin
          dx = x - int'(trk_last_x);
          dy = y - int'(trk_last_y);
        end
        if (go && (dx != 0 || dy != 0)) begin
          if (!trk_sel_drag) begin
            lim = 2 * int'(cfg_model.max_pan_step);
            r.pan_dx = PAN_W'(clamp_pan(3 * dx, lim));
            r.pan_dy = PAN_W'(clamp_pan(3 * dy, lim));
          end else begin
            r.pan_dx = PAN_W'(2 * dx);
            r.pan_dy = PAN_W'(2 * dy);
          end
          trk_last_x = ev.pos_x;
          trk_last_y = ev.pos_y;
          r.pan_valid = 1'b1;
          trk_moved = 1'b1;
        end
      end
    end
  endtask

  // Hold the event and count it until its result comes back
  task automatic queue_event(logic [1:0] op, logic [ID_W-1:0] id, int x, int y, bit sel);
    evt_t ev;
    ev.op = op;
    ev.touch_id = id;
    ev.pos_x = POS_W'(x);
    ev.pos_y = POS_W'(y);
    ev.selection_enabled = sel;
    pending_events.push_back(ev);
    events_in_flight++;
    events_queued++;
  endtask

  function automatic int nudge(int p, int span);
    int v;
    v = p + $urandom_range(0, 2 * span) - span;
    if (v < 0) return 0;
    if (v > 1023) return 1023;
    return v;
  endfunction

  // One gesture: a stray event, a tap in the button region, or a drag
  task automatic queue_gesture();
    logic [ID_W-1:0] id;
    int  x, y, kind, steps, span, r;
    bit  sel;
    id = ID_W'($urandom_range(0, 255));
    sel = ($urandom_range(0, 3) == 0);
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      queue_event(2'($urandom_range(0, 3)), ID_W'($urandom_range(0, 255)),
                  $urandom_range(0, 1023), $urandom_range(0, 1023),
                  1'($urandom_range(0, 1)));
    end else if (kind <= 2) begin
      x = $urandom_range(cfg_model.button_min_x, 1023);
      if (cfg_model.button_min_y <= cfg_model.button_max_y)
        y = $urandom_range(cfg_model.button_min_y, cfg_model.button_max_y);
      else
        y = $urandom_range(0, 1023);
      queue_event(OP_DOWN, id, x, y, sel);
      if ($urandom_range(0, 1)) queue_event(OP_MOVE, id, nudge(x, 3), nudge(y, 3), sel);
      queue_event(OP_UP, id, x, y, sel);
    end else begin
      x = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 959);
      y = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 543);
      queue_event(OP_DOWN, id, x, y, sel);
      steps = $urandom_range(1, 10);
      span = ($urandom_range(0, 3) == 0) ? 400 : 24;
      for (int s = 0; s < steps; s++) begin
        r = $urandom_range(0, 19);
        x = nudge(x, span);
        y = nudge(y, span);
        if (r == 0) queue_event(OP_MOVE, id ^ 8'h5A, x, y, sel);
        else if (r == 1) queue_event(OP_SPARE, id, x, y, sel);
        else if (r == 2) queue_event(OP_MOVE, id, x, y, !sel);
        else queue_event(OP_MOVE, id, x, y, sel);
      end
      if ($urandom_range(0, 7) == 0) queue_event(OP_UP, ~id, x, y, sel);
      if ($urandom_range(0, 7) != 0) queue_event(OP_UP, id, x, y, sel);
    end
  endtask

  // Write one register; the caller lowers cfg_valid after its last write
  task automatic write_reg(cfg_reg_t idx, logic [CFGD_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SLOP_RADIUS:  cfg_model.slop_radius = val[7:0];
      REG_MAX_PAN_STEP: cfg_model.max_pan_step = val[7:0];
      REG_BUTTON_MIN_X: cfg_model.button_min_x = val;
      REG_BUTTON_MIN_Y: cfg_model.button_min_y = val;
      REG_BUTTON_MAX_Y: cfg_model.button_max_y = val;
      default: ;
    endcase
  endtask

  task automatic program_setting(logic [CFGD_W-1:0] slop, logic [CFGD_W-1:0] step,
                                 logic [CFGD_W-1:0] bx, logic [CFGD_W-1:0] by0,
                                 logic [CFGD_W-1:0] by1);
    write_reg(REG_SLOP_RADIUS, slop);
    write_reg(REG_MAX_PAN_STEP, step);
    write_reg(REG_BUTTON_MIN_X, bx);
    write_reg(REG_BUTTON_MIN_Y, by0);
    write_reg(REG_BUTTON_MAX_Y, by1);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_idle();
    while (events_in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Drive requests from the pending queue and predict each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        track_touch(offered_event, predicted);
        expected_results.push_back(predicted);
        events_accepted++;
      end
      if (!in_tvalid || in_tready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_tvalid <= 1'b0;
        end else if (pending_events.size() != 0) begin
          offered_event = pending_events.pop_front();
          in_tdata <= {3'b000, offered_event.selection_enabled, offered_event.pos_y,
                       offered_event.pos_x, offered_event.touch_id};
          in_tuser <= offered_event.op;
          in_tvalid <= 1'b1;
          send_gap = pick_gap();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Accept results, check them in order, and stall at random
  always @(posedge clk) begin
    res_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.action = out_tuser;
        got.out_id = out_tdata[7:0];
        got.out_x = out_tdata[17:8];
        got.out_y = out_tdata[27:18];
        got.pan_valid = out_tdata[28];
        got.pan_dx = out_tdata[40:29];
        got.pan_dy = out_tdata[52:41];
        got.armed_now = out_tdata[53];
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual id %0d x %0d y %0d",
                   $time, got.out_id, got.out_x, got.out_y);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          compare_field("action", want.action, got.action);
          compare_field("out_id", want.out_id, got.out_id);
          compare_field("out_x", want.out_x, got.out_x);
          compare_field("out_y", want.out_y, got.out_y);
          compare_field("pan_valid", want.pan_valid, got.pan_valid);
          compare_field("pan_dx", want.pan_dx, got.pan_dx);
          compare_field("pan_dy", want.pan_dy, got.pan_dy);
          compare_field("armed_now", want.armed_now, got.armed_now);
          if (want.pan_valid) pans_seen++;
          if (want.armed_now) arms_seen++;
          results_checked++;
          events_in_flight--;
        end
        recv_gap = pick_gap();
      end
      if (hold_off) begin
        out_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Back-pressure: block results for long stretches so the core fills up
  initial begin
    wait (events_accepted >= 150);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
    wait (events_accepted >= 450);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (300) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #1000000;
    $display("TEST FAILED");
    $finish;
  end

  // Reset, directed events, then random phases under changing settings
  initial begin
    cfg_model.slop_radius = SLOP_RADIUS_RST;
    cfg_model.max_pan_step = MAX_PAN_STEP_RST;
    cfg_model.button_min_x = BUTTON_MIN_X_RST;
    cfg_model.button_min_y = BUTTON_MIN_Y_RST;
    cfg_model.button_max_y = BUTTON_MAX_Y_RST;
    trk_moved = 1'b0;
    trk_active = 1'b0;
    trk_id = '0;
    trk_down_x = '0;
    trk_down_y = '0;
    trk_last_x = '0;
    trk_last_y = '0;
    trk_sel_armed = 1'b0;
    trk_sel_drag = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Normal drag: inside the slop, exactly on it, clamped steps, zero step
    queue_event(OP_DOWN, 8'h00, 0, 0, 1'b0);
    queue_event(OP_MOVE, 8'h00, 0, 5, 1'b0);
    queue_event(OP_MOVE, 8'h00, 16, 0, 1'b0);
    queue_event(OP_MOVE, 8'h00, 40, 0, 1'b0);
    queue_event(OP_MOVE, 8'h00, 0, 0, 1'b0);
    queue_event(OP_MOVE, 8'h00, 0, 0, 1'b0);
    queue_event(OP_MOVE, 8'h07, 300, 200, 1'b0);
    queue_event(OP_SPARE, 8'h00, 5, 5, 1'b0);
    queue_event(OP_UP, 8'h09, 1023, 1023, 1'b0);
    queue_event(OP_UP, 8'h00, 959, 543, 1'b0);
    queue_event(OP_MOVE, 8'h00, 10, 10, 1'b0);
    // Untouched release in the button region arms, a second one stays armed
    queue_event(OP_DOWN, 8'hFF, 900, 400, 1'b1);
    queue_event(OP_UP, 8'hFF, 900, 400, 1'b1);
    queue_event(OP_UP, 8'hFF, 880, 470, 1'b1);
    // Selection drag: unclamped offsets from the down point at full range
    queue_event(OP_DOWN, 8'h55, 1023, 1023, 1'b1);
    queue_event(OP_MOVE, 8'h55, 1023, 1020, 1'b1);
    queue_event(OP_MOVE, 8'h55, 0, 0, 1'b1);
    queue_event(OP_MOVE, 8'h55, 1023, 0, 1'b0);
    queue_event(OP_MOVE, 8'h55, 1023, 1023, 1'b1);
    queue_event(OP_UP, 8'hAA, 500, 300, 1'b0);
    queue_event(OP_UP, 8'h55, 1023, 1023, 1'b1);
    // Normal mode with selection enabled pans on the first crossing
    queue_event(OP_DOWN, 8'hAA, 100, 100, 1'b1);
    queue_event(OP_MOVE, 8'hAA, 200, 100, 1'b1);
    queue_event(OP_UP, 8'hAA, 879, 379, 1'b1);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: program_setting(0, 0, 0, 0, 0);
        1: program_setting(255, 255, 959, 543, 543);
        default: program_setting(
                   CFGD_W'($urandom_range(0, 40) | ($urandom_range(0, 3) << 8)),
                   CFGD_W'($urandom_range(0, 255) | ($urandom_range(0, 3) << 8)),
                   CFGD_W'($urandom_range(600, 959)), CFGD_W'($urandom_range(0, 543)),
                   CFGD_W'($urandom_range(0, 543)));
      endcase
      idle_gaps = (p != 3);
      begin
        int start;
        start = events_queued;
        while (events_queued - start < 105) queue_gesture();
      end
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (expected_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
      mismatches++;
    end
    $display("Checked %0d forwarded events under %0d register settings,", results_checked,
             settings_used);
    $display("including %0d pan deltas and %0d selection arms.", pans_seen, arms_seen);
    if (mismatches == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
